// File: rtl/skrt_pkg.sv
// Package for the shared key reference count table.
// Types, sizes and codes shared by the controller, datapath and top level.
// No dependencies.
package skrt_pkg;

  localparam int unsigned ENTRIES   = 64;
  localparam int unsigned IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned KEY_W     = 32;
  localparam int unsigned COUNT_W   = 16;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_CLAIM = COUNT_W'(2);
  localparam logic [COUNT_W-1:0] COUNT_ONE   = COUNT_W'(1);

  typedef enum logic {
    CMD_RETAIN  = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e             command;
    logic [KEY_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic still_shared;
    logic dropped;
  } out_item_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [COUNT_W-1:0] count;
  } entry_t;

  // Controller to datapath.
  typedef struct packed {
    logic             start;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             eval;
    logic [IDX_W-1:0] eval_idx;
    logic             commit;
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

// File: rtl/skrt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Used for the key/count table. No dependencies.
module skrt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/skrt_ctrl.sv
// Controller state machine: input handshake, scan address counter, commit timing.
// Depends on skrt_pkg.
module skrt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  skrt_pkg::dp_status_t status_i,
  output skrt_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_UPDATE = 4'b1000
  } state_e;

  localparam logic [skrt_pkg::IDX_W-1:0] LAST_IDX = skrt_pkg::IDX_W'(skrt_pkg::ENTRIES - 1);

  state_e                     state_q, state_d;
  logic [skrt_pkg::IDX_W-1:0] addr_q, addr_d;
  logic                       eval_q;
  logic [skrt_pkg::IDX_W-1:0] eval_idx_q;
  logic                       start;
  logic                       commit;

  assign in_stall_o = (state_q != ST_IDLE);
  assign start      = in_valid_i && (state_q == ST_IDLE);
  assign commit     = (state_q == ST_UPDATE) && status_i.out_free;

  always_comb begin
    state_d = state_q;
    addr_d  = addr_q;
    unique case (state_q)
      ST_IDLE: begin
        addr_d = '0;
        if (in_valid_i) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (addr_q == LAST_IDX) begin
          state_d = ST_DRAIN;
        end else begin
          addr_d = addr_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      addr_q     <= '0;
      eval_q     <= 1'b0;
      eval_idx_q <= '0;
    end else begin
      state_q    <= state_d;
      addr_q     <= addr_d;
      eval_q     <= (state_q == ST_SCAN);
      eval_idx_q <= addr_q;
    end
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.start    = start;
    cmd_o.rd_en    = (state_q == ST_SCAN);
    cmd_o.rd_addr  = addr_q;
    cmd_o.eval     = eval_q;
    cmd_o.eval_idx = eval_idx_q;
    cmd_o.commit   = commit;
  end

endmodule

// File: rtl/skrt_dp.sv
// Datapath: item register, table RAM, live bits, match/free tracking, result register.
// Depends on skrt_pkg and skrt_ram.
module skrt_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  skrt_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output skrt_pkg::out_item_t  out_item_o,
  input  skrt_pkg::ctrl_cmd_t  cmd_i,
  output skrt_pkg::dp_status_t status_o
);

  skrt_pkg::in_item_t             item_q;
  logic [skrt_pkg::ENTRIES-1:0]   live_q, live_d;
  logic                           hit_q, free_q;
  logic [skrt_pkg::IDX_W-1:0]     hit_idx_q, free_idx_q;
  logic [skrt_pkg::COUNT_W-1:0]   hit_cnt_q;
  skrt_pkg::out_item_t            out_q, res;
  logic                           out_valid_q;

  skrt_pkg::entry_t               rd_entry, wr_entry;
  logic [$bits(skrt_pkg::entry_t)-1:0] rdata;
  logic                           we;
  logic [skrt_pkg::IDX_W-1:0]     waddr;
  logic                           rd_live, rd_match;
  logic [skrt_pkg::COUNT_W-1:0]   dec_cnt;

  skrt_ram #(
    .WIDTH ($bits(skrt_pkg::entry_t)),
    .DEPTH (skrt_pkg::ENTRIES),
    .AW    (skrt_pkg::IDX_W)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wr_entry),
    .re_i    (cmd_i.rd_en),
    .raddr_i (cmd_i.rd_addr),
    .rdata_o (rdata)
  );

  assign rd_entry = skrt_pkg::entry_t'(rdata);
  assign rd_live  = live_q[cmd_i.eval_idx];
  assign rd_match = rd_live && (rd_entry.key == item_q.key);
  assign dec_cnt  = hit_cnt_q - skrt_pkg::COUNT_ONE;

  assign status_o.out_free = !out_valid_q || !out_stall_i;

  // Table update and result, applied on commit.
  always_comb begin
    we       = 1'b0;
    waddr    = hit_idx_q;
    wr_entry = '{key: item_q.key, count: skrt_pkg::COUNT_CLAIM};
    live_d   = live_q;
    res      = '0;
    if (item_q.command == skrt_pkg::CMD_RETAIN) begin
      if (hit_q) begin
        we             = cmd_i.commit;
        wr_entry.count = (hit_cnt_q == skrt_pkg::COUNT_MAX) ? hit_cnt_q
                                                            : hit_cnt_q + 1'b1;
      end else if (free_q) begin
        we    = cmd_i.commit;
        waddr = free_idx_q;
        if (cmd_i.commit) begin
          live_d[free_idx_q] = 1'b1;
        end
      end else begin
        res.dropped = 1'b1;
      end
    end else if (hit_q) begin
      res.still_shared = 1'b1;
      if (dec_cnt <= skrt_pkg::COUNT_ONE) begin
        if (cmd_i.commit) begin
          live_d[hit_idx_q] = 1'b0;
        end
      end else begin
        we             = cmd_i.commit;
        wr_entry.count = dec_cnt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      item_q <= in_item_i;
    end
    if (cmd_i.eval && rd_match && !hit_q) begin
      hit_idx_q <= cmd_i.eval_idx;
      hit_cnt_q <= rd_entry.count;
    end
    if (cmd_i.eval && !rd_live && !free_q) begin
      free_idx_q <= cmd_i.eval_idx;
    end
    if (cmd_i.commit) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q      <= '0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      live_q <= live_d;
      if (cmd_i.start) begin
        hit_q  <= 1'b0;
        free_q <= 1'b0;
      end else if (cmd_i.eval) begin
        if (rd_match) begin
          hit_q <= 1'b1;
        end
        if (!rd_live) begin
          free_q <= 1'b1;
        end
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// File: rtl/shared_key_refcount_table_top.sv
// Top level of the shared key reference count table.
// Depends on skrt_pkg, skrt_ctrl, skrt_dp (which holds skrt_ram).
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_item_i): one item carries a
//   command (retain or release) and a 32-bit key. An item is taken on a clock
//   edge with in_valid_i high and in_stall_o low.
//   Output channel (out_valid_o / out_stall_i / out_item_o): exactly one
//   result item per input item, in order: still_shared for a release that
//   found its key, dropped for a retain that found neither a match nor a
//   free slot.
//   Timing: after an item is taken the table is scanned one entry per cycle
//   through the single read port of the table RAM, then a drain state
//   finishes the compare and an update state commits the update once the
//   result register is free. A new item is taken only when the controller
//   is back in idle after that commit.
//   Stall: the result register parts the two sides, so the next item is taken
//   and scanned while a result still waits; its commit waits until the
//   result register is free.
//   Reset: asynchronous, active low. All live bits clear, so the table reads
//   as empty at once; no clearing pass is needed.
module shared_key_refcount_table_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  skrt_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output skrt_pkg::out_item_t out_item_o
);

  skrt_pkg::ctrl_cmd_t  cmd;
  skrt_pkg::dp_status_t status;

  // Sequencer: handshake, scan addresses, commit.
  skrt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Table, match tracking and result register.
  skrt_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule
